// ===== sv/dcpq_pkg.sv =====
package dcpq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_W = 32;
	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int ACT_W = 2;
	localparam int STAT_W = 3;
	localparam int CNTO_W = 5;

	localparam logic [ACT_W-1:0] ACT_ADD = 2'd0;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_PLAY = 2'd2;

	localparam logic [STAT_W-1:0] ST_ADDED = 3'd0;
	localparam logic [STAT_W-1:0] ST_DUP = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL = 3'd2;
	localparam logic [STAT_W-1:0] ST_REMOVED = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;
	localparam logic [STAT_W-1:0] ST_PLAYED = 3'd5;
	localparam logic [STAT_W-1:0] ST_EMPTY = 3'd6;

	typedef struct packed {
		logic [ID_W-1:0] song_id;
		logic [ACT_W-1:0] action;
	} cmd_t;

	typedef struct packed {
		logic [CNTO_W-1:0] entry_count;
		logic current_valid;
		logic [ID_W-1:0] current_id;
		logic [ID_W-1:0] played_id;
		logic [STAT_W-1:0] status;
	} result_t;

endpackage

// ===== sv/dcpq_engine.sv =====
module dcpq_engine
	import dcpq_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input cmd_t cmd,
	input logic res_ready,
	output logic idle,
	output logic done,
	output result_t res
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SCAN_RD = 4'd1;
	localparam logic [3:0] S_SCAN_CMP = 4'd2;
	localparam logic [3:0] S_APPEND = 4'd3;
	localparam logic [3:0] S_SH_RD = 4'd4;
	localparam logic [3:0] S_SH_WR = 4'd5;
	localparam logic [3:0] S_RM_FIN = 4'd6;
	localparam logic [3:0] S_PLAY_RD = 4'd7;
	localparam logic [3:0] S_PLAY_WT = 4'd8;
	localparam logic [3:0] S_CUR_RD = 4'd9;
	localparam logic [3:0] S_CUR_WT = 4'd10;

	logic [ID_W-1:0] ids_q [QUEUE_DEPTH];
	logic [ID_W-1:0] rdata_q;

	logic [3:0] state_q;
	logic [ACT_W-1:0] act_q;
	logic [ID_W-1:0] id_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] pos_q;
	logic [IDX_W-1:0] cursor_q;
	logic [CNT_W-1:0] count_q;
	logic cur_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [ID_W-1:0] played_q;

	logic [IDX_W-1:0] raddr;
	logic we;
	logic [IDX_W-1:0] waddr;
	logic [ID_W-1:0] wdata;
	logic [CNT_W-1:0] idx_nx;
	logic [CNT_W-1:0] cur_nx;
	logic [CNT_W-1:0] cnt_dec;

	assign idx_nx = CNT_W'(idx_q) + CNT_W'(1);
	assign cur_nx = CNT_W'(cursor_q) + CNT_W'(1);
	assign cnt_dec = count_q - CNT_W'(1);

	always_comb begin
		case (state_q)
			S_SH_RD: raddr = IDX_W'(idx_nx);
			S_PLAY_RD, S_CUR_RD, S_CUR_WT: raddr = cursor_q;
			default: raddr = idx_q;
		endcase
	end

	always_comb begin
		we = 1'b0;
		waddr = idx_q;
		wdata = rdata_q;
		case (state_q)
			S_APPEND: begin
				we = 1'b1;
				waddr = IDX_W'(count_q);
				wdata = id_q;
			end
			S_SH_WR: begin
				we = 1'b1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			ids_q[waddr] <= wdata;
		end
		rdata_q <= ids_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			cursor_q <= '0;
			cur_valid_q <= 1'b0;
			act_q <= '0;
			id_q <= '0;
			idx_q <= '0;
			pos_q <= '0;
			status_q <= '0;
			played_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						act_q <= cmd.action;
						id_q <= cmd.song_id;
						played_q <= '0;
						idx_q <= '0;
						case (cmd.action)
							ACT_ADD: begin
								state_q <= (count_q == '0) ? S_APPEND : S_SCAN_RD;
							end
							ACT_REMOVE: begin
								if (count_q == '0) begin
									status_q <= ST_NOTFOUND;
									state_q <= S_CUR_RD;
								end else begin
									state_q <= S_SCAN_RD;
								end
							end
							ACT_PLAY: begin
								if (cur_valid_q) begin
									state_q <= S_PLAY_RD;
								end else begin
									status_q <= ST_EMPTY;
									state_q <= S_CUR_RD;
								end
							end
							default: begin
								status_q <= ST_NOTFOUND;
								state_q <= S_CUR_RD;
							end
						endcase
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CMP;
				end
				S_SCAN_CMP: begin
					if (rdata_q == id_q) begin
						if (act_q == ACT_ADD) begin
							status_q <= ST_DUP;
							state_q <= S_CUR_RD;
						end else begin
							pos_q <= idx_q;
							state_q <= (idx_nx < count_q) ? S_SH_RD : S_RM_FIN;
						end
					end else if (idx_nx == count_q) begin
						if (act_q == ACT_ADD) begin
							if (count_q == CNT_W'(QUEUE_DEPTH)) begin
								status_q <= ST_FULL;
								state_q <= S_CUR_RD;
							end else begin
								state_q <= S_APPEND;
							end
						end else begin
							status_q <= ST_NOTFOUND;
							state_q <= S_CUR_RD;
						end
					end else begin
						idx_q <= IDX_W'(idx_nx);
						state_q <= S_SCAN_RD;
					end
				end
				S_APPEND: begin
					count_q <= count_q + CNT_W'(1);
					if (!cur_valid_q) begin
						cursor_q <= '0;
						cur_valid_q <= 1'b1;
					end
					status_q <= ST_ADDED;
					state_q <= S_CUR_RD;
				end
				S_SH_RD: begin
					state_q <= S_SH_WR;
				end
				S_SH_WR: begin
					if ((idx_nx + CNT_W'(1)) < count_q) begin
						idx_q <= IDX_W'(idx_nx);
						state_q <= S_SH_RD;
					end else begin
						state_q <= S_RM_FIN;
					end
				end
				S_RM_FIN: begin
					count_q <= cnt_dec;
					if (cur_valid_q && cursor_q == pos_q) begin
						if (cnt_dec == '0) begin
							cursor_q <= '0;
							cur_valid_q <= 1'b0;
						end else if (CNT_W'(pos_q) >= cnt_dec) begin
							cursor_q <= '0;
						end
					end else if (cur_valid_q && pos_q < cursor_q) begin
						cursor_q <= cursor_q - IDX_W'(1);
					end
					status_q <= ST_REMOVED;
					state_q <= S_CUR_RD;
				end
				S_PLAY_RD: begin
					state_q <= S_PLAY_WT;
				end
				S_PLAY_WT: begin
					played_q <= rdata_q;
					cursor_q <= (cur_nx >= count_q) ? '0 : IDX_W'(cur_nx);
					status_q <= ST_PLAYED;
					state_q <= S_CUR_RD;
				end
				S_CUR_RD: begin
					state_q <= S_CUR_WT;
				end
				S_CUR_WT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle = (state_q == S_IDLE);
	assign done = (state_q == S_CUR_WT) && res_ready;

	always_comb begin
		res.status = status_q;
		res.played_id = played_q;
		res.current_id = cur_valid_q ? rdata_q : '0;
		res.current_valid = cur_valid_q;
		res.entry_count = CNTO_W'(count_q);
	end

	a_cursor_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> (CNT_W'(cursor_q) < count_q))
		else $error("cursor points past the last entry");

	a_valid_iff_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) == !cur_valid_q)
		else $error("cursor valid flag disagrees with entry count");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count exceeds queue depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |=> (count_q == $past(count_q)))
		else $error("entry count changed while idle");

endmodule

// ===== sv/dedup_cyclic_play_queue.sv =====
// Play next reads the entry at the cursor, advances the cursor (wrapping to the first entry)
// and then reads the new current entry for the result. Add and remove compare the stored
// entries in order, and remove then shifts each later entry down one place; both end by
// reading the current entry. The engine takes a new item only when idle, after the last result
// has gone to the output register, where it waits while the next item is accepted.
// Reset empties the list and clears the cursor at once; the id store itself is not cleared.
module dedup_cyclic_play_queue
	import dcpq_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [39:0] s_tdata, // action[1:0], song_id[33:2], zero[39:34]
	output logic m_tvalid,
	input logic m_tready,
	output logic [79:0] m_tdata // status, played_id, current_id, current_valid, entry_count, zero
);

	cmd_t cmd;
	result_t res;
	logic eng_idle;
	logic eng_done;
	logic res_ready;
	logic m_tvalid_q;
	result_t m_res_q;

	assign cmd.action = s_tdata[ACT_W-1:0];
	assign cmd.song_id = s_tdata[ACT_W+ID_W-1:ACT_W];
	assign s_tready = eng_idle;
	assign res_ready = !m_tvalid_q || m_tready;

	dcpq_engine u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.start(s_tvalid && s_tready),
		.cmd(cmd),
		.res_ready(res_ready),
		.idle(eng_idle),
		.done(eng_done),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (eng_done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_done) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {7'd0, m_res_q};

endmodule
